@@ design/ioir_pkg.sv @@
// ----------------------------------------------------------------------------
// ioir_pkg: shared types and constants for the interrupt redirector
// Operation and result codes, window offsets and controller/datapath links.
// ----------------------------------------------------------------------------
package ioir_pkg;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_PIN   = 2'd2;

    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_DELIV = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [7:0] ADDR_SELECT = 8'h00;
    localparam logic [7:0] ADDR_DATA   = 8'h10;

    localparam logic [7:0] SEL_ID      = 8'h00;
    localparam logic [7:0] SEL_VERSION = 8'h01;
    localparam logic [7:0] SEL_ARB     = 8'h02;
    localparam logic [7:0] SEL_TABLE   = 8'h10;

    localparam logic [2:0] MODE_EXTINT = 3'd7;
    localparam logic [31:0] ENTRY_RESET_LO = 32'h0001_0000;

    // entry bit positions
    localparam int BIT_STATUS  = 12;
    localparam int BIT_TRIGGER = 15;
    localparam int BIT_MASK    = 16;

    // controller -> datapath commands
    typedef struct packed {
        logic load;      // capture the request
        logic exec;      // perform register access / pin update
        logic scan_init; // start rescan at pin 0
        logic scan_step; // visit current pin
        logic out_load;  // load output register from current step
    } ioir_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic has_result;  // register access gives one result
        logic start_scan;  // access/pin event needs a rescan
        logic scan_hit;    // current pin emits a delivery
        logic scan_done;   // current pin is the last one
        logic more_hits;   // any hit remains after the current pin
    } ioir_stat_t;

endpackage

@@ design/ioir_datapath.sv @@
// ----------------------------------------------------------------------------
// ioir_datapath: register file, redirection table and scan datapath
// Holds all architectural state and forms the result payload.
// ----------------------------------------------------------------------------
module ioir_datapath #(
    parameter int NUM_PINS     = 24,
    parameter int RESET_ID     = 1,
    parameter logic [31:0] VERSION_WORD = 32'd1507345
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ioir_pkg::ioir_cmd_t cmd,
    output ioir_pkg::ioir_stat_t stat,
    input  logic [1:0]          operation,
    input  logic [7:0]          address,
    input  logic [31:0]         write_data,
    input  logic [4:0]          pin,
    input  logic                level,
    input  logic                bus_accepts,
    input  logic [7:0]          external_vector,
    output logic [1:0]          kind,
    output logic [31:0]         read_data,
    output logic [7:0]          vector,
    output logic [7:0]          destination,
    output logic [2:0]          deliv_mode,
    output logic                logical_destination,
    output logic                active_low,
    output logic                level_triggered,
    output logic [4:0]          source_pin,
    output logic                last
);
    import ioir_pkg::*;

    localparam int PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    // captured request
    logic [1:0]  op_reg;
    logic [7:0]  addr_reg;
    logic [31:0] wdata_reg;
    logic [4:0]  pin_reg;
    logic        level_reg;
    logic        acc_reg;
    logic [7:0]  extv_reg;

    // architectural state
    logic [7:0]          sel_reg;
    logic [3:0]          id_reg;
    logic [63:0]         tbl_reg [NUM_PINS];
    logic [NUM_PINS-1:0] lvl_reg;
    logic [NUM_PINS-1:0] pend_reg;
    logic [PW-1:0]       scan_reg;

    // result staging from register access
    logic [1:0]  acc_kind;
    logic [31:0] acc_data;

    // decode of the table index from select
    logic [7:0]    sel_off;
    logic          sel_is_entry;
    logic [PW-1:0] sel_idx;
    logic          pin_ok;
    logic [PW-1:0] pin_idx;

    // scan hits: pending and unmasked, and pins after the current one
    logic [NUM_PINS-1:0] hit_vec;
    logic [NUM_PINS-1:0] later;

    always_comb
    begin
        sel_off      = sel_reg - SEL_TABLE;
        sel_is_entry = (sel_reg >= SEL_TABLE) && ({1'b0, sel_off[7:1]} < NUM_PINS);
        sel_idx      = PW'(sel_off[7:1]);
        pin_ok       = ({3'b0, pin_reg} < NUM_PINS);
        pin_idx      = PW'(pin_reg);
    end

    // register access decode and scan status
    always_comb
    begin
        acc_kind = KIND_READ;
        acc_data = '0;
        stat.has_result = 1'b0;
        stat.start_scan = 1'b0;
        unique case (op_reg)
            OP_READ:
            begin
                stat.has_result = 1'b1;
                if (addr_reg == ADDR_SELECT)
                    acc_data = {24'b0, sel_reg};
                else if (addr_reg != ADDR_DATA)
                    acc_kind = KIND_ERROR;
                else if (sel_reg == SEL_ID)
                    acc_data = {4'b0, id_reg, 24'b0};
                else if (sel_reg == SEL_VERSION)
                    acc_data = VERSION_WORD;
                else if (sel_reg == SEL_ARB)
                    acc_data = '0;
                else if (sel_is_entry)
                    acc_data = sel_reg[0] ? tbl_reg[sel_idx][63:32]
                                          : tbl_reg[sel_idx][31:0];
                else
                    acc_kind = KIND_ERROR;
            end
            OP_WRITE:
            begin
                if (addr_reg == ADDR_SELECT || sel_reg == SEL_ID ||
                    sel_reg == SEL_VERSION || sel_reg == SEL_ARB)
                begin
                    if (addr_reg != ADDR_SELECT && addr_reg != ADDR_DATA)
                    begin
                        stat.has_result = 1'b1;
                        acc_kind = KIND_ERROR;
                    end
                end
                else if (addr_reg != ADDR_DATA || !sel_is_entry)
                begin
                    stat.has_result = 1'b1;
                    acc_kind = KIND_ERROR;
                end
                else
                    stat.start_scan = 1'b1;
            end
            OP_PIN:
                stat.start_scan = pin_ok && level_reg && !lvl_reg[pin_idx];
            default: ;
        endcase
        stat.scan_hit  = hit_vec[scan_reg];
        stat.scan_done = (int'(scan_reg) == NUM_PINS - 1);
        stat.more_hits = |(hit_vec & later);
    end

    // hit vector over all pins
    always_comb
    begin
        for (int i = 0; i < NUM_PINS; i++)
        begin
            hit_vec[i] = pend_reg[i] && !tbl_reg[i][BIT_MASK];
            later[i]   = (i > int'(scan_reg));
        end
    end

    logic [63:0] cur_e;
    assign cur_e = tbl_reg[scan_reg];

    // state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg  <= '0;
            id_reg   <= 4'(RESET_ID);
            lvl_reg  <= '0;
            pend_reg <= '0;
            scan_reg <= '0;
            for (int i = 0; i < NUM_PINS; i++)
                tbl_reg[i] <= {32'b0, ENTRY_RESET_LO};
        end
        else
        begin
            if (cmd.exec)
            begin
                if (op_reg == OP_WRITE && addr_reg == ADDR_SELECT)
                    sel_reg <= wdata_reg[7:0];
                else if (op_reg == OP_WRITE && addr_reg == ADDR_DATA)
                begin
                    if (sel_reg == SEL_ID)
                        id_reg <= wdata_reg[27:24];
                    else if (sel_reg != SEL_VERSION && sel_reg != SEL_ARB && sel_is_entry)
                    begin
                        if (sel_reg[0])
                            tbl_reg[sel_idx][63:32] <= wdata_reg;
                        else
                            tbl_reg[sel_idx][31:0] <= wdata_reg;
                    end
                end
                else if (op_reg == OP_PIN && pin_ok && (level_reg != lvl_reg[pin_idx]))
                begin
                    lvl_reg[pin_idx] <= level_reg;
                    if (level_reg)
                        pend_reg[pin_idx] <= 1'b1;
                    else if (tbl_reg[pin_idx][BIT_TRIGGER])
                        pend_reg[pin_idx] <= 1'b0;
                end
            end
            if (cmd.scan_init)
                scan_reg <= '0;
            else if (cmd.scan_step)
            begin
                if (stat.scan_hit)
                begin
                    if (acc_reg)
                    begin
                        if (!cur_e[BIT_TRIGGER])
                            pend_reg[scan_reg] <= 1'b0;
                        tbl_reg[scan_reg][BIT_STATUS] <= 1'b0;
                    end
                    else
                        tbl_reg[scan_reg][BIT_STATUS] <= 1'b1;
                end
                if (!stat.scan_done)
                    scan_reg <= scan_reg + PW'(1);
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            addr_reg  <= address;
            wdata_reg <= write_data;
            pin_reg   <= pin;
            level_reg <= level;
            acc_reg   <= bus_accepts;
            extv_reg  <= external_vector;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.scan_step)
            begin
                kind                <= KIND_DELIV;
                read_data           <= '0;
                deliv_mode          <= cur_e[10:8];
                vector              <= (cur_e[10:8] == MODE_EXTINT) ? extv_reg : cur_e[7:0];
                destination         <= cur_e[63:56];
                logical_destination <= cur_e[11];
                active_low          <= cur_e[13];
                level_triggered     <= cur_e[15];
                source_pin          <= 5'(scan_reg);
                last                <= stat.scan_done || !stat.more_hits;
            end
            else
            begin
                kind                <= acc_kind;
                read_data           <= (acc_kind == KIND_READ) ? acc_data : '0;
                deliv_mode          <= '0;
                vector              <= '0;
                destination         <= '0;
                logical_destination <= 1'b0;
                active_low          <= 1'b0;
                level_triggered     <= 1'b0;
                source_pin          <= '0;
                last                <= 1'b1;
            end
        end
    end

endmodule

@@ design/ioir_ctrl.sv @@
// ----------------------------------------------------------------------------
// ioir_ctrl: sequencer for access, rescan and result handoff
// Takes one request, runs its access, walks the pins and feeds the output.
// ----------------------------------------------------------------------------
module ioir_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 valid,
    output logic                 ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output ioir_pkg::ioir_cmd_t  cmd,
    input  ioir_pkg::ioir_stat_t stat
);
    import ioir_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_WAIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       slot_free;

    assign slot_free = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign ready     = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
                if (valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            S_EXEC:
                if (stat.has_result)
                begin
                    if (slot_free)
                    begin
                        cmd.out_load = 1'b1;
                        ov_next      = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.exec = 1'b1;
                    if (stat.start_scan)
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = S_SCAN;
                    end
                    else
                        state_next = S_IDLE;
                end
            S_SCAN:
                if (!stat.scan_hit || slot_free)
                begin
                    cmd.scan_step = 1'b1;
                    if (stat.scan_hit)
                    begin
                        cmd.out_load = 1'b1;
                        ov_next      = 1'b1;
                    end
                    if (stat.scan_done || (stat.scan_hit && !stat.more_hits))
                        state_next = S_WAIT;
                end
            S_WAIT:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    // a loaded result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!ov_reg || out_ready))
        else $error("result overwritten");
    // a step only happens while scanning
    a_step_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> state_reg == S_SCAN)
        else $error("scan step outside scan");
    // a request is taken only when idle and leads into EXEC
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_EXEC)
        else $error("load sequence broken");

endmodule

@@ design/io_interrupt_redirector_top.sv @@
// ----------------------------------------------------------------------------
// io_interrupt_redirector_top: indirect-window I/O interrupt redirector
// Register window, 24-entry redirection table and in-order delivery rescan.
// ----------------------------------------------------------------------------
// Channel   Handshake            Payload
// input     valid / ready        operation address write_data pin level
//                                bus_accepts external_vector
// output    out_valid/out_ready  kind read_data vector destination
//                                deliv_mode logical_destination active_low
//                                level_triggered source_pin last
//
// A register access runs in the EXEC state, and a rescan walks the table from pin 0:
// the scan visits one table entry per cycle.
// Output stalls hold the scan on a hit pin; the output register frees the
// block to take the next request while the final result waits.
// Reset is asynchronous; table entries reset to masked.
// ----------------------------------------------------------------------------
module io_interrupt_redirector_top #(
    parameter int NUM_PINS     = 24,
    parameter int RESET_ID     = 1,
    parameter logic [31:0] VERSION_WORD = 32'd1507345
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [1:0]  operation,
    input  logic [7:0]  address,
    input  logic [31:0] write_data,
    input  logic [4:0]  pin,
    input  logic        level,
    input  logic        bus_accepts,
    input  logic [7:0]  external_vector,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [31:0] read_data,
    output logic [7:0]  vector,
    output logic [7:0]  destination,
    output logic [2:0]  deliv_mode,
    output logic        logical_destination,
    output logic        active_low,
    output logic        level_triggered,
    output logic [4:0]  source_pin,
    output logic        last
);
    import ioir_pkg::*;

    ioir_cmd_t  cmd;
    ioir_stat_t stat;

    ioir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .ready     (ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    ioir_datapath #(
        .NUM_PINS     (NUM_PINS),
        .RESET_ID     (RESET_ID),
        .VERSION_WORD (VERSION_WORD)
    ) u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .stat                (stat),
        .operation           (operation),
        .address             (address),
        .write_data          (write_data),
        .pin                 (pin),
        .level               (level),
        .bus_accepts         (bus_accepts),
        .external_vector     (external_vector),
        .kind                (kind),
        .read_data           (read_data),
        .vector              (vector),
        .destination         (destination),
        .deliv_mode          (deliv_mode),
        .logical_destination (logical_destination),
        .active_low          (active_low),
        .level_triggered     (level_triggered),
        .source_pin          (source_pin),
        .last                (last)
    );

endmodule
